@@ rtl/core/dts_pkg.sv @@
// Shared types, codes and the scanner transition table for the token scanner.
// Used by dts_step, dts_res_queue and dfa_token_scanner_core; depends on nothing.
package dts_pkg;

  localparam int CNT_BITS_DEF = 16;
  localparam int OUT_BITS     = 16;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic {
    ACT_CHAR = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef enum logic [4:0] {
    S_NONE         = 5'd0,
    S_START        = 5'd1,
    S_NUM          = 5'd2,
    S_NUM_DOT      = 5'd3,
    S_NUM_FRAC     = 5'd4,
    S_NUM_EXP      = 5'd5,
    S_NUM_EXP_SIGN = 5'd6,
    S_NUM_EXP_DIG  = 5'd7,
    S_LIT_OPEN     = 5'd8,
    S_LIT          = 5'd9,
    S_ID           = 5'd10,
    S_EOF          = 5'd11,
    S_CMT_OPEN     = 5'd12,
    S_CMT          = 5'd13,
    S_LT           = 5'd14,
    S_ASSIGN       = 5'd15,
    S_RELOP2       = 5'd16,
    S_GT           = 5'd17,
    S_ARITH        = 5'd18,
    S_LPAREN       = 5'd19,
    S_RPAREN       = 5'd20,
    S_SEMI         = 5'd21
  } scan_state_t;

  typedef enum logic [3:0] {
    TOK_ERROR   = 4'd0,
    TOK_NUM     = 4'd1,
    TOK_LITERAL = 4'd2,
    TOK_ID      = 4'd3,
    TOK_EOF     = 4'd4,
    TOK_COMMENT = 4'd5,
    TOK_RELOP   = 4'd6,
    TOK_ASSIGN  = 4'd7,
    TOK_ARITH   = 4'd8,
    TOK_LPAREN  = 4'd9,
    TOK_RPAREN  = 4'd10,
    TOK_SEMI    = 4'd11
  } tok_class_t;

  typedef struct packed {
    tok_class_t          token_class;
    logic [OUT_BITS-1:0] lexeme_length;
    logic [OUT_BITS-1:0] line_number;
    logic [OUT_BITS-1:0] column_number;
    logic                last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  // Returns S_NONE where the character has no transition.
  function automatic scan_state_t next_state(input scan_state_t s, input logic [7:0] c);
    logic digit;
    logic letter;
    logic printable;
    scan_state_t n;
    digit     = (c >= 8'h30) && (c <= 8'h39);
    letter    = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    printable = (c >= CH_SPACE) && (c < CH_DEL);
    n         = S_NONE;
    case (s)
      S_START: begin
        if (is_space(c)) n = S_START;
        else if (digit) n = S_NUM;
        else if (c == CH_QUOTE) n = S_LIT_OPEN;
        else if (letter) n = S_ID;
        else if (c == CH_DOLLAR) n = S_EOF;
        else if (c == CH_LBRACE) n = S_CMT_OPEN;
        else if (c == CH_LT) n = S_LT;
        else if (c == CH_EQ) n = S_RELOP2;
        else if (c == CH_GT) n = S_GT;
        else if ((c == CH_SLASH) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR))
          n = S_ARITH;
        else if (c == CH_LPAREN) n = S_LPAREN;
        else if (c == CH_RPAREN) n = S_RPAREN;
        else if (c == CH_SEMI) n = S_SEMI;
      end
      S_NUM: begin
        if (digit) n = S_NUM;
        else if (c == CH_DOT) n = S_NUM_DOT;
        else if (c == CH_UPPER_E) n = S_NUM_EXP;
      end
      S_NUM_DOT, S_NUM_FRAC: begin
        if (digit) n = S_NUM_FRAC;
      end
      S_NUM_EXP: begin
        if (digit) n = S_NUM_EXP_DIG;
        else if ((c == CH_PLUS) || (c == CH_MINUS)) n = S_NUM_EXP_SIGN;
      end
      S_NUM_EXP_SIGN, S_NUM_EXP_DIG: begin
        if (digit) n = S_NUM_EXP_DIG;
      end
      S_LIT_OPEN: begin
        if (c == CH_QUOTE) n = S_LIT;
        else if (printable) n = S_LIT_OPEN;
      end
      S_ID: begin
        if (digit || letter || (c == CH_UNDER)) n = S_ID;
      end
      S_CMT_OPEN: begin
        if (c == CH_RBRACE) n = S_CMT;
        else if (printable) n = S_CMT_OPEN;
      end
      S_LT: begin
        if (c == CH_MINUS) n = S_ASSIGN;
        else if ((c == CH_GT) || (c == CH_EQ)) n = S_RELOP2;
      end
      S_GT: begin
        if (c == CH_EQ) n = S_RELOP2;
      end
      default: n = S_NONE;
    endcase
    return n;
  endfunction

  // Non-final states report an error token.
  function automatic tok_class_t class_of_state(input scan_state_t s);
    tok_class_t t;
    case (s)
      S_NUM, S_NUM_FRAC, S_NUM_EXP_DIG: t = TOK_NUM;
      S_LIT:                            t = TOK_LITERAL;
      S_ID:                             t = TOK_ID;
      S_EOF:                            t = TOK_EOF;
      S_CMT:                            t = TOK_COMMENT;
      S_LT, S_RELOP2, S_GT:             t = TOK_RELOP;
      S_ASSIGN:                         t = TOK_ASSIGN;
      S_ARITH:                          t = TOK_ARITH;
      S_LPAREN:                         t = TOK_LPAREN;
      S_RPAREN:                         t = TOK_RPAREN;
      S_SEMI:                           t = TOK_SEMI;
      default:                          t = TOK_ERROR;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/dts_step.sv @@
// One scanner step: next DFA state, counter updates and the zero to two tokens
// that one input word causes. Purely combinational; uses dts_pkg.
module dts_step import dts_pkg::*; #(
  parameter int COUNTER_BITS = CNT_BITS_DEF
) (
  input  action_t                 action,
  input  logic [7:0]              character,
  input  scan_state_t             state_cur,
  input  logic [COUNTER_BITS-1:0] lex_cur,
  input  logic [COUNTER_BITS-1:0] line_cur,
  input  logic [COUNTER_BITS-1:0] col_cur,
  output scan_state_t             state_nxt,
  output logic [COUNTER_BITS-1:0] lex_nxt,
  output logic [COUNTER_BITS-1:0] line_nxt,
  output logic [COUNTER_BITS-1:0] col_nxt,
  output result_pair_t            results
);

  localparam int XW = (COUNTER_BITS > OUT_BITS) ? COUNTER_BITS : OUT_BITS;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    return (v == {COUNTER_BITS{1'b1}}) ? v : v + COUNTER_BITS'(1);
  endfunction

  function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNTER_BITS-1:0] v);
    logic [XW-1:0] e;
    e = XW'(v);
    return (e > XW'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : e[OUT_BITS-1:0];
  endfunction

  scan_state_t             nx_first;
  scan_state_t             nx_eff;
  logic                    pending;
  logic [COUNTER_BITS-1:0] lex_base;
  logic [COUNTER_BITS-1:0] col_err;

  assign pending  = (state_cur != S_START);
  assign nx_first = next_state(state_cur, character);
  // A refused character after a pending token is rescanned from the start state.
  assign nx_eff   = (nx_first != S_NONE) ? nx_first
                  : (pending ? next_state(S_START, character) : S_NONE);
  assign lex_base = (nx_first != S_NONE) ? lex_cur : '0;
  assign col_err  = sat_inc(col_cur);

  // Next state and counters.
  always_comb begin
    state_nxt = state_cur;
    lex_nxt   = lex_cur;
    line_nxt  = line_cur;
    col_nxt   = col_cur;
    if (action == ACT_END) begin
      if (pending) begin
        state_nxt = S_START;
        lex_nxt   = '0;
      end
    end else if (nx_eff != S_NONE) begin
      state_nxt = nx_eff;
      lex_nxt   = is_space(character) ? lex_base : sat_inc(lex_base);
      if (character == CH_NL) begin
        line_nxt = sat_inc(line_cur);
        col_nxt  = COUNTER_BITS'(2);
      end else begin
        col_nxt  = sat_inc(col_cur);
      end
    end else begin
      state_nxt = S_START;
      lex_nxt   = '0;
      col_nxt   = col_err;
    end
  end

  // Tokens; the pending token carries the counters from before this character.
  always_comb begin
    result_t tok_res;
    result_t err_res;
    tok_res.token_class   = class_of_state(state_cur);
    tok_res.lexeme_length = sat_out(lex_cur);
    tok_res.line_number   = sat_out(line_cur);
    tok_res.column_number = sat_out(col_cur);
    tok_res.last_of_run   = 1'b1;
    err_res.token_class   = TOK_ERROR;
    err_res.lexeme_length = '0;
    err_res.line_number   = sat_out(line_cur);
    err_res.column_number = sat_out(col_err);
    err_res.last_of_run   = 1'b1;
    results.count  = 2'd0;
    results.first  = tok_res;
    results.second = err_res;
    if (action == ACT_END) begin
      if (pending) results.count = 2'd1;
    end else if (nx_first == S_NONE) begin
      if (pending) begin
        results.first.last_of_run = (nx_eff != S_NONE);
        results.count = (nx_eff != S_NONE) ? 2'd1 : 2'd2;
      end else begin
        results.first = err_res;
        results.count = 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/dts_res_queue.sv @@
// Small register queue for result words: takes up to two per cycle, gives one per cycle while out_ready is high.
// Uses the result types of dts_pkg.
module dts_res_queue import dts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  result_pair_t push_data,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output result_t      out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push    = push ? push_data.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  // Room for the worst case of two results from the next word.
  assign room      = (count_r <= CNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) entry_r[wr_ptr_r] <= push_data.first;
    if (n_push == 2'd2) entry_r[wr_ptr_r + PTR_W'(1)] <= push_data.second;
  end

endmodule

@@ rtl/core/dfa_token_scanner_core.sv @@
// Longest-match DFA token scanner, one source character per word.
// The tokens that a taken word ends are written into the result queue and offered on out_ from there.
// Throughput: one word per cycle while the four-entry result queue has room for two;
// a word that yields two tokens puts both in the queue, which gives them out one at a time.
// Reset (synchronous, rst_n low): start state, lexeme count 0, line and column 1,
// result queue empty.
module dfa_token_scanner_core import dts_pkg::*; #(
  parameter int COUNTER_BITS = CNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_token_class,
  output logic [15:0] out_lexeme_length,
  output logic [15:0] out_line_number,
  output logic [15:0] out_column_number,
  output logic       out_last_of_run
);

  scan_state_t             scan_state_r, scan_state_nxt;
  logic [COUNTER_BITS-1:0] lex_r, lex_nxt;
  logic [COUNTER_BITS-1:0] line_r, line_nxt;
  logic [COUNTER_BITS-1:0] col_r, col_nxt;
  result_pair_t            step_res;
  result_t                 head;
  logic                    take;

  assign take = in_valid && in_ready;

  dts_step #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_step (
    .action    (action_t'(in_action)),
    .character (in_character),
    .state_cur (scan_state_r),
    .lex_cur   (lex_r),
    .line_cur  (line_r),
    .col_cur   (col_r),
    .state_nxt (scan_state_nxt),
    .lex_nxt   (lex_nxt),
    .line_nxt  (line_nxt),
    .col_nxt   (col_nxt),
    .results   (step_res)
  );

  dts_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (step_res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_state_r <= S_START;
      lex_r        <= '0;
      line_r       <= COUNTER_BITS'(1);
      col_r        <= COUNTER_BITS'(1);
    end else if (take) begin
      scan_state_r <= scan_state_nxt;
      lex_r        <= lex_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
    end
  end

  assign out_token_class   = head.token_class;
  assign out_lexeme_length = head.lexeme_length;
  assign out_line_number   = head.line_number;
  assign out_column_number = head.column_number;
  assign out_last_of_run   = head.last_of_run;

endmodule

@@ sim/dfa_token_scanner_core_tb.sv @@
// Self-checking testbench for dfa_token_scanner_core: directed and random character streams
// with random idling on both channels. Depends on dts_pkg and the scanner RTL only.
module dfa_token_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dts_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_character;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_token_class;
  logic [15:0] out_lexeme_length;
  logic [15:0] out_line_number;
  logic [15:0] out_column_number;
  logic        out_last_of_run;

  // Scanner state as the testbench tracks it.
  scan_state_t  dfa_state  = S_START;
  logic [15:0]  lex_count  = 16'd0;
  logic [15:0]  line_count = 16'd1;
  logic [15:0]  col_count  = 16'd1;

  result_t      expected_tokens[$];
  result_t      oldest_token;
  int           errors     = 0;
  int           words_sent = 0;
  bit           in_idle    = 1'b1;
  bit           out_idle   = 1'b1;

  dfa_token_scanner_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_character      (in_character),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_class   (out_token_class),
    .out_lexeme_length (out_lexeme_length),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic scan_state_t dfa_move(input scan_state_t s, input logic [7:0] ch);
    logic dig;
    logic alpha;
    logic prn;
    logic blank;
    dig   = (ch >= 8'h30) && (ch <= 8'h39);
    alpha = ((ch | 8'h20) >= 8'h61) && ((ch | 8'h20) <= 8'h7A);
    prn   = (ch >= CH_SPACE) && (ch < CH_DEL);
    blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
    case (s)
      S_START: begin
        if (blank) return S_START;
        if (dig) return S_NUM;
        if (alpha) return S_ID;
        case (ch)
          CH_QUOTE:  return S_LIT_OPEN;
          CH_DOLLAR: return S_EOF;
          CH_LBRACE: return S_CMT_OPEN;
          CH_LT:     return S_LT;
          CH_EQ:     return S_RELOP2;
          CH_GT:     return S_GT;
          CH_SLASH, CH_PLUS, CH_MINUS, CH_STAR: return S_ARITH;
          CH_LPAREN: return S_LPAREN;
          CH_RPAREN: return S_RPAREN;
          CH_SEMI:   return S_SEMI;
          default:   return S_NONE;
        endcase
      end
      S_NUM: begin
        if (dig) return S_NUM;
        if (ch == CH_DOT) return S_NUM_DOT;
        if (ch == CH_UPPER_E) return S_NUM_EXP;
      end
      S_NUM_DOT, S_NUM_FRAC: if (dig) return S_NUM_FRAC;
      S_NUM_EXP: begin
        if (dig) return S_NUM_EXP_DIG;
        if ((ch == CH_PLUS) || (ch == CH_MINUS)) return S_NUM_EXP_SIGN;
      end
      S_NUM_EXP_SIGN, S_NUM_EXP_DIG: if (dig) return S_NUM_EXP_DIG;
      S_LIT_OPEN: begin
        if (ch == CH_QUOTE) return S_LIT;
        if (prn) return S_LIT_OPEN;
      end
      S_ID: if (dig || alpha || (ch == CH_UNDER)) return S_ID;
      S_CMT_OPEN: begin
        if (ch == CH_RBRACE) return S_CMT;
        if (prn) return S_CMT_OPEN;
      end
      S_LT: begin
        if (ch == CH_MINUS) return S_ASSIGN;
        if ((ch == CH_GT) || (ch == CH_EQ)) return S_RELOP2;
      end
      S_GT: if (ch == CH_EQ) return S_RELOP2;
      default: return S_NONE;
    endcase
    return S_NONE;
  endfunction

  function automatic tok_class_t token_of(input scan_state_t s);
    case (s)
      S_NUM, S_NUM_FRAC, S_NUM_EXP_DIG: return TOK_NUM;
      S_LIT:                            return TOK_LITERAL;
      S_ID:                             return TOK_ID;
      S_EOF:                            return TOK_EOF;
      S_CMT:                            return TOK_COMMENT;
      S_LT, S_RELOP2, S_GT:             return TOK_RELOP;
      S_ASSIGN:                         return TOK_ASSIGN;
      S_ARITH:                          return TOK_ARITH;
      S_LPAREN:                         return TOK_LPAREN;
      S_RPAREN:                         return TOK_RPAREN;
      S_SEMI:                           return TOK_SEMI;
      default:                          return TOK_ERROR;
    endcase
  endfunction

  function automatic result_t make_token(input tok_class_t cls, input logic [15:0] len);
    result_t r;
    r.token_class   = cls;
    r.lexeme_length = len;
    r.line_number   = line_count;
    r.column_number = col_count;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // Advances the tracked scanner by one word and queues the tokens it yields.
  task automatic predict_word(input action_t act, input logic [7:0] ch);
    result_t     toks[2];
    int          n;
    scan_state_t nx;
    n = 0;
    if (act == ACT_END) begin
      if (dfa_state != S_START) begin
        toks[n] = make_token(token_of(dfa_state), lex_count);
        n = n + 1;
        dfa_state = S_START;
        lex_count = 16'd0;
      end
    end else begin
      nx = dfa_move(dfa_state, ch);
      if (nx == S_NONE && dfa_state != S_START) begin
        // The pending token ends here; the same character is rescanned from start.
        toks[n] = make_token(token_of(dfa_state), lex_count);
        n = n + 1;
        dfa_state = S_START;
        lex_count = 16'd0;
        nx = dfa_move(S_START, ch);
      end
      if (nx != S_NONE) begin
        if ((ch != CH_SPACE) && (ch != CH_TAB) && (ch != CH_NL)) lex_count = bump(lex_count);
        if (ch == CH_NL) begin
          line_count = bump(line_count);
          col_count  = 16'd1;
        end
        dfa_state = nx;
        col_count = bump(col_count);
      end else begin
        col_count = bump(col_count);
        toks[n] = make_token(TOK_ERROR, 16'd0);
        n = n + 1;
        lex_count = 16'd0;
      end
    end
    if (n > 0) toks[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_tokens.push_back(toks[i]);
  endtask

  task automatic flag_error(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_word(input action_t act, input logic [7:0] ch);
    int gap;
    bit taken;
    gap = in_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_character <= ch;
    taken = 1'b0;
    // Valid and ready are stable at the falling edge, so the word is taken at the next rise.
    while (!taken) begin
      @(negedge clk);
      if (in_ready) begin
        taken = 1'b1;
        predict_word(act, ch);
      end
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(ACT_CHAR, s[i]);
  endtask

  task automatic test_end_and_refusals();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_word(ACT_END, 8'h00);
    send_word(ACT_CHAR, 8'h00);
    send_word(ACT_CHAR, 8'hFF);
    send_text("x_9");
    send_word(ACT_CHAR, 8'h80);
    send_word(ACT_CHAR, CH_LBRACE);
    send_word(ACT_END, 8'hFF);
  endtask

  task automatic test_numbers();
    send_text("12.5E-3;7E");
    send_word(ACT_END, 8'h5A);
  endtask

  task automatic test_operators_and_text();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    send_text("<-<>>=(=)*\"q\"{c}$\n\t");
    send_word(ACT_END, 8'h00);
  endtask

  // Mostly well-formed tokens with random content, plus raw bytes, flushes and
  // tokens whose last character is replaced by a random byte.
  task automatic test_random_stream();
    logic [7:0] lexeme_buf[$];
    int         pick;
    int         kind;
    int         cnt;
    logic [7:0] ch;
    while (words_sent < 1800) begin
      if ($urandom_range(0, 63) == 0) begin
        in_idle  = ($urandom_range(0, 3) != 0);
        out_idle = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(ACT_CHAR, 8'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        send_word(ACT_END, 8'($urandom_range(0, 255)));
      end else begin
        lexeme_buf.delete();
        kind = $urandom_range(0, 7);
        case (kind)
          0: begin
            cnt = $urandom_range(1, 4);
            repeat (cnt) lexeme_buf.push_back(8'($urandom_range(48, 57)));
            if ($urandom_range(0, 1)) begin
              lexeme_buf.push_back(CH_DOT);
              repeat ($urandom_range(1, 3)) lexeme_buf.push_back(8'($urandom_range(48, 57)));
            end
            if ($urandom_range(0, 1)) begin
              lexeme_buf.push_back(CH_UPPER_E);
              if ($urandom_range(0, 1))
                lexeme_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
              repeat ($urandom_range(1, 2)) lexeme_buf.push_back(8'($urandom_range(48, 57)));
            end
          end
          1: begin
            lexeme_buf.push_back(8'($urandom_range(0, 1) ? $urandom_range(65, 90)
                                                          : $urandom_range(97, 122)));
            cnt = $urandom_range(0, 6);
            repeat (cnt) begin
              case ($urandom_range(0, 3))
                0: ch = 8'($urandom_range(48, 57));
                1: ch = CH_UNDER;
                2: ch = 8'($urandom_range(65, 90));
                default: ch = 8'($urandom_range(97, 122));
              endcase
              lexeme_buf.push_back(ch);
            end
          end
          2, 3: begin
            lexeme_buf.push_back(kind == 2 ? CH_QUOTE : CH_LBRACE);
            cnt = $urandom_range(0, 5);
            repeat (cnt) begin
              ch = 8'($urandom_range(32, 126));
              if ((ch == CH_QUOTE) || (ch == CH_RBRACE)) ch = CH_SPACE;
              lexeme_buf.push_back(ch);
            end
            lexeme_buf.push_back(kind == 2 ? CH_QUOTE : CH_RBRACE);
          end
          4: begin
            case ($urandom_range(0, 6))
              0: lexeme_buf.push_back(CH_LT);
              1: begin
                lexeme_buf.push_back(CH_LT);
                lexeme_buf.push_back(CH_MINUS);
              end
              2: begin
                lexeme_buf.push_back(CH_LT);
                lexeme_buf.push_back(CH_EQ);
              end
              3: begin
                lexeme_buf.push_back(CH_LT);
                lexeme_buf.push_back(CH_GT);
              end
              4: lexeme_buf.push_back(CH_EQ);
              5: lexeme_buf.push_back(CH_GT);
              default: begin
                lexeme_buf.push_back(CH_GT);
                lexeme_buf.push_back(CH_EQ);
              end
            endcase
          end
          5: begin
            case ($urandom_range(0, 3))
              0: lexeme_buf.push_back(CH_SLASH);
              1: lexeme_buf.push_back(CH_PLUS);
              2: lexeme_buf.push_back(CH_MINUS);
              default: lexeme_buf.push_back(CH_STAR);
            endcase
          end
          6: begin
            case ($urandom_range(0, 3))
              0: lexeme_buf.push_back(CH_LPAREN);
              1: lexeme_buf.push_back(CH_RPAREN);
              2: lexeme_buf.push_back(CH_SEMI);
              default: lexeme_buf.push_back(CH_DOLLAR);
            endcase
          end
          default: begin
            case ($urandom_range(0, 2))
              0: lexeme_buf.push_back(CH_SPACE);
              1: lexeme_buf.push_back(CH_TAB);
              default: lexeme_buf.push_back(CH_NL);
            endcase
          end
        endcase
        if (pick < 20) lexeme_buf[lexeme_buf.size()-1] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) lexeme_buf.push_back(CH_SPACE);
        foreach (lexeme_buf[i]) send_word(ACT_CHAR, lexeme_buf[i]);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_CHAR;
    in_character = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_end_and_refusals();
    test_numbers();
    test_operators_and_text();
    test_random_stream();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    int stall;
    bit done;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      done = 1'b0;
      while (!done) begin
        @(negedge clk);
        done = out_valid;
        @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        flag_error($sformatf("unexpected word, class %0d", out_token_class));
      end else begin
        oldest_token = expected_tokens.pop_front();
        if (out_token_class != oldest_token.token_class)
          flag_error($sformatf("token_class got %0d want %0d",
                               out_token_class, oldest_token.token_class));
        if (out_lexeme_length != oldest_token.lexeme_length)
          flag_error($sformatf("lexeme_length got %0d want %0d",
                               out_lexeme_length, oldest_token.lexeme_length));
        if (out_line_number != oldest_token.line_number)
          flag_error($sformatf("line_number got %0d want %0d",
                               out_line_number, oldest_token.line_number));
        if (out_column_number != oldest_token.column_number)
          flag_error($sformatf("column_number got %0d want %0d",
                               out_column_number, oldest_token.column_number));
        if (out_last_of_run != oldest_token.last_of_run)
          flag_error($sformatf("last_of_run got %0d want %0d",
                               out_last_of_run, oldest_token.last_of_run));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dts_pkg.sv
rtl/core/dts_step.sv
rtl/core/dts_res_queue.sv
rtl/core/dfa_token_scanner_core.sv
sim/dfa_token_scanner_core_tb.sv
